// ----- hdl/hbd_pkg.sv -----
// Shared types, codes and constants of the bounded HTTP body deframer.
// Used by hbd_core, hbd_out_buf and bounded_http_body_deframer; no dependencies.
package hbd_pkg;

	localparam int unsigned CNT_W = 17;
	localparam int unsigned MS_W = 16;
	localparam int unsigned SLACK_W = 15;
	localparam int unsigned LINE_W = 10;
	localparam int unsigned DIG_W = 4;

	localparam logic [CNT_W-1:0] MAX_BODY = 17'd65536;
	localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;
	localparam logic [LINE_W-1:0] SIZE_LINE_LIMIT = 10'd128;
	localparam logic [LINE_W-1:0] TRAILER_LINE_LIMIT = 10'd512;
	localparam logic [DIG_W-1:0] MAX_SIZE_DIGITS = 4'd8;

	localparam logic [MS_W-1:0] TIMEOUT_RST = 16'd20000;
	localparam logic [CNT_W-1:0] BODY_LIMIT_RST = 17'd65536;
	localparam logic [SLACK_W-1:0] RAW_SLACK_RST = 15'd8192;

	// configuration register indexes
	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_BODY_LIMIT = 2'd1;
	localparam logic [1:0] REG_RAW_SLACK = 2'd2;

	// input item kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;
	localparam logic [1:0] KIND_TICK = 2'd3;

	// body modes
	localparam logic [1:0] MODE_CLOSE = 2'd0;
	localparam logic [1:0] MODE_LENGTH = 2'd1;
	localparam logic [1:0] MODE_CHUNKED = 2'd2;
	localparam logic [1:0] MODE_BAD = 2'd3;

	// end status codes
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_TIMEOUT = 3'd1;
	localparam logic [2:0] ST_RAW = 3'd2;
	localparam logic [2:0] ST_OVER = 3'd3;
	localparam logic [2:0] ST_FRAME = 3'd4;
	localparam logic [2:0] ST_CLOSED = 3'd5;
	localparam logic [2:0] ST_EMPTY = 3'd6;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	typedef enum logic [9:0] {
		PH_IDLE    = 10'b00_0000_0001,
		PH_SIZE    = 10'b00_0000_0010,
		PH_SIZE_LF = 10'b00_0000_0100,
		PH_DATA    = 10'b00_0000_1000,
		PH_DATA_CR = 10'b00_0001_0000,
		PH_DATA_LF = 10'b00_0010_0000,
		PH_TRL     = 10'b00_0100_0000,
		PH_TRL_LF  = 10'b00_1000_0000,
		PH_LEN     = 10'b01_0000_0000,
		PH_CLOSE   = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [MS_W-1:0]    timeout_ms;
		logic [CNT_W-1:0]   body_limit;
		logic [SLACK_W-1:0] raw_slack;
	} cfg_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       done_res;
		logic [2:0] status;
	} res_t;

	// {valid, value} of an ASCII hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			return {1'b1, d[3:0]};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			return {1'b1, d[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

endpackage

// ----- hdl/hbd_out_buf.sv -----
// Two-entry result buffer between the deframer logic and the output stream.
// Depends on hbd_pkg (res_t).
module hbd_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hbd_pkg::res_t push_data,
	output logic          has_room,
	output logic          out_vld,
	input  logic          out_rdy,
	output hbd_pkg::res_t out_data
);

	hbd_pkg::res_t e0_q, e1_q;
	logic [1:0] cnt_q;
	logic pop;

	assign pop = out_vld && out_rdy;
	assign out_vld = (cnt_q != 2'd0);
	assign out_data = e0_q;
	assign has_room = (cnt_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && cnt_q == 2'd1) e0_q <= push_data;
			else e0_q <= e1_q;
			if (push && cnt_q == 2'd2) e1_q <= push_data;
		end else if (push) begin
			if (cnt_q == 2'd0) e0_q <= push_data;
			else e1_q <= push_data;
		end
	end

endmodule

// ----- hdl/hbd_core.sv -----
// Response state and per-item update of the body deframer: one item per cycle while take is high.
// Depends on hbd_pkg (phase_t, cfg_t, res_t, codes, hex_value).
module hbd_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic [1:0]                kind,
	input  logic [1:0]                body_mode,
	input  logic [hbd_pkg::CNT_W-1:0] content_length,
	input  logic [7:0]                rx_byte,
	input  hbd_pkg::cfg_t             cfg,
	output logic                      res_vld,
	output hbd_pkg::res_t             res
);

	hbd_pkg::phase_t phase_q, phase_d;
	logic [hbd_pkg::CNT_W-1:0] remaining_q, remaining_d;
	logic [hbd_pkg::CNT_W-1:0] body_q, body_d;     // body bytes of this response
	logic [hbd_pkg::CNT_W-1:0] raw_q, raw_d;
	logic [hbd_pkg::MS_W-1:0] elapsed_q, elapsed_d;
	logic [hbd_pkg::LINE_W-1:0] line_q, line_d;
	logic [hbd_pkg::DIG_W-1:0] digits_q, digits_d;
	logic semi_q, semi_d;

	logic [hbd_pkg::CNT_W-1:0] eff_body, eff_raw, raw_inc, room;
	logic [hbd_pkg::CNT_W:0] raw_sum;
	logic [hbd_pkg::MS_W-1:0] elapsed_inc;
	logic [4:0] hexd;
	logic [20:0] acc;
	logic emit, fin;
	logic [2:0] st;

	assign eff_body = (cfg.body_limit < hbd_pkg::MAX_BODY) ? cfg.body_limit
	                                                       : hbd_pkg::MAX_BODY;
	assign raw_sum = {1'b0, eff_body} + {3'b000, cfg.raw_slack};
	assign eff_raw = raw_sum[hbd_pkg::CNT_W] ? hbd_pkg::CNT_MAX : raw_sum[hbd_pkg::CNT_W-1:0];
	// body room left under the current limit
	assign room = (body_q >= eff_body) ? '0 : eff_body - body_q;
	assign raw_inc = raw_q + 17'd1;
	assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
	assign hexd = hbd_pkg::hex_value(rx_byte);
	assign acc = {remaining_q, 4'b0000} + {17'd0, hexd[3:0]};

	always_comb begin
		phase_d = phase_q;
		remaining_d = remaining_q;
		body_d = body_q;
		raw_d = raw_q;
		elapsed_d = elapsed_q;
		line_d = line_q;
		digits_d = digits_q;
		semi_d = semi_q;
		emit = 1'b0;
		fin = 1'b0;
		st = hbd_pkg::ST_OK;

		if (take) begin
			if (kind == hbd_pkg::KIND_START) begin
				remaining_d = '0;
				body_d = '0;
				raw_d = '0;
				elapsed_d = '0;
				line_d = '0;
				digits_d = '0;
				semi_d = 1'b0;
				unique case (body_mode)
					hbd_pkg::MODE_CHUNKED: phase_d = hbd_pkg::PH_SIZE;
					hbd_pkg::MODE_CLOSE:   phase_d = hbd_pkg::PH_CLOSE;
					hbd_pkg::MODE_BAD: begin
						fin = 1'b1;
						st = hbd_pkg::ST_FRAME;
					end
					default: begin
						priority if (content_length > eff_body) begin
							fin = 1'b1;
							st = hbd_pkg::ST_OVER;
						end else if (content_length == '0) begin
							fin = 1'b1;
							st = hbd_pkg::ST_EMPTY;
						end else begin
							remaining_d = content_length;
							phase_d = hbd_pkg::PH_LEN;
						end
					end
				endcase
			end else if (phase_q == hbd_pkg::PH_IDLE) begin
				// stray byte, close or tick: ignored
			end else if (kind == hbd_pkg::KIND_TICK) begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= cfg.timeout_ms) begin
					fin = 1'b1;
					st = hbd_pkg::ST_TIMEOUT;
				end
			end else if (elapsed_q >= cfg.timeout_ms) begin
				fin = 1'b1;
				st = hbd_pkg::ST_TIMEOUT;
			end else if (raw_q >= eff_raw) begin
				fin = 1'b1;
				st = hbd_pkg::ST_RAW;
			end else if (kind == hbd_pkg::KIND_CLOSE) begin
				fin = 1'b1;
				if (phase_q == hbd_pkg::PH_CLOSE)
					st = (body_q != '0) ? hbd_pkg::ST_OK : hbd_pkg::ST_EMPTY;
				else st = hbd_pkg::ST_CLOSED;
			end else begin
				raw_d = raw_inc;
				unique case (phase_q)
					hbd_pkg::PH_SIZE: begin
						priority if (rx_byte == hbd_pkg::CH_CR) begin
							phase_d = hbd_pkg::PH_SIZE_LF;
						end else if (rx_byte == hbd_pkg::CH_LF ||
						             line_q >= hbd_pkg::SIZE_LINE_LIMIT) begin
							fin = 1'b1;
							st = hbd_pkg::ST_FRAME;
						end else begin
							line_d = line_q + 10'd1;
							// extensions after a semicolon are skipped
							priority if (semi_q) begin
							end else if (rx_byte == hbd_pkg::CH_SEMI) begin
								semi_d = 1'b1;
							end else begin
								digits_d = digits_q + 4'd1;
								priority if (digits_q >= hbd_pkg::MAX_SIZE_DIGITS || !hexd[4]) begin
									fin = 1'b1;
									st = hbd_pkg::ST_FRAME;
								end else begin
									remaining_d = acc[hbd_pkg::CNT_W-1:0];
									if (acc > {4'd0, room}) begin
										fin = 1'b1;
										st = hbd_pkg::ST_OVER;
									end
								end
							end
						end
					end
					hbd_pkg::PH_SIZE_LF: begin
						if (rx_byte != hbd_pkg::CH_LF || digits_q == '0) begin
							fin = 1'b1;
							st = hbd_pkg::ST_FRAME;
						end else begin
							line_d = '0;
							digits_d = '0;
							semi_d = 1'b0;
							phase_d = (remaining_q == '0) ? hbd_pkg::PH_TRL : hbd_pkg::PH_DATA;
						end
					end
					hbd_pkg::PH_DATA: begin
						emit = 1'b1;
						body_d = body_q + 17'd1;
						remaining_d = remaining_q - 17'd1;
						if (remaining_q == 17'd1) phase_d = hbd_pkg::PH_DATA_CR;
					end
					hbd_pkg::PH_DATA_CR: begin
						if (rx_byte != hbd_pkg::CH_CR) begin
							fin = 1'b1;
							st = hbd_pkg::ST_FRAME;
						end else begin
							phase_d = hbd_pkg::PH_DATA_LF;
						end
					end
					hbd_pkg::PH_DATA_LF: begin
						if (rx_byte != hbd_pkg::CH_LF) begin
							fin = 1'b1;
							st = hbd_pkg::ST_FRAME;
						end else begin
							line_d = '0;
							digits_d = '0;
							semi_d = 1'b0;
							remaining_d = '0;
							phase_d = hbd_pkg::PH_SIZE;
						end
					end
					hbd_pkg::PH_TRL: begin
						priority if (rx_byte == hbd_pkg::CH_CR) begin
							phase_d = hbd_pkg::PH_TRL_LF;
						end else if (rx_byte == hbd_pkg::CH_LF ||
						             line_q >= hbd_pkg::TRAILER_LINE_LIMIT) begin
							fin = 1'b1;
							st = hbd_pkg::ST_FRAME;
						end else begin
							line_d = line_q + 10'd1;
						end
					end
					hbd_pkg::PH_TRL_LF: begin
						priority if (rx_byte != hbd_pkg::CH_LF) begin
							fin = 1'b1;
							st = hbd_pkg::ST_FRAME;
						end else if (line_q == '0) begin
							fin = 1'b1;
							st = (body_q != '0) ? hbd_pkg::ST_OK : hbd_pkg::ST_EMPTY;
						end else begin
							line_d = '0;
							phase_d = hbd_pkg::PH_TRL;
						end
					end
					hbd_pkg::PH_LEN: begin
						emit = 1'b1;
						body_d = body_q + 17'd1;
						remaining_d = remaining_q - 17'd1;
						if (remaining_q == 17'd1) begin
							fin = 1'b1;
							st = hbd_pkg::ST_OK;
						end
					end
					hbd_pkg::PH_CLOSE: begin
						if (room == '0) begin
							fin = 1'b1;
							st = hbd_pkg::ST_OVER;
						end else begin
							emit = 1'b1;
							body_d = body_q + 17'd1;
						end
					end
					default: begin
						fin = 1'b1;
						st = hbd_pkg::ST_FRAME;
					end
				endcase
				if (!fin && raw_inc >= eff_raw) begin
					fin = 1'b1;
					st = hbd_pkg::ST_RAW;
				end
			end
			if (fin) phase_d = hbd_pkg::PH_IDLE;
		end
	end

	assign res_vld = emit || fin;
	assign res.out_valid = emit;
	assign res.out_byte = emit ? rx_byte : 8'd0;
	assign res.done_res = fin;
	assign res.status = fin ? st : hbd_pkg::ST_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hbd_pkg::PH_IDLE;
			remaining_q <= '0;
			body_q <= '0;
			raw_q <= '0;
			elapsed_q <= '0;
			line_q <= '0;
			digits_q <= '0;
			semi_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			remaining_q <= remaining_d;
			body_q <= body_d;
			raw_q <= raw_d;
			elapsed_q <= elapsed_d;
			line_q <= line_d;
			digits_q <= digits_d;
			semi_q <= semi_d;
		end
	end

endmodule

// ----- hdl/bounded_http_body_deframer.sv -----
// Top level of the bounded HTTP body deframer: stream ports, config registers.
// Depends on hbd_pkg, hbd_core and hbd_out_buf.
//
//  channel   | dir | handshake                   | payload
//  ----------+-----+-----------------------------+---------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready | tuser kind; tdata mode, length, byte
//  m_axis    | out | m_axis_tvalid/m_axis_tready | tuser valid/done flags; tdata byte, status
//  cfg       | in  | cfg_we (no wait)            | cfg_index, cfg_data
//
// One transfer is taken per cycle while s_axis_tready is high; its result, if any, is in
// the output buffer the next cycle.
// The two-entry output buffer keeps the input open while one result waits; s_axis_tready
// drops only when both entries are full, i.e. after the sink has stalled for two results.
// arst_n clears the response state to idle, empties the buffer and loads the default
// timeout (20000 ms), body limit (65536) and raw slack (8192).
module bounded_http_body_deframer (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [1:0] body_mode, [18:2] content_length,
	                                    // [26:19] rx_byte, [31:27] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] kind

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
	output logic [1:0]  m_axis_tuser,   // [0] out_valid, [1] done_res

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	hbd_pkg::cfg_t cfg_q;
	hbd_pkg::res_t res, out_res;
	logic res_vld, room, take;

	// Config registers; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms <= hbd_pkg::TIMEOUT_RST;
			cfg_q.body_limit <= hbd_pkg::BODY_LIMIT_RST;
			cfg_q.raw_slack <= hbd_pkg::RAW_SLACK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hbd_pkg::REG_TIMEOUT:    cfg_q.timeout_ms <= cfg_data[15:0];
				hbd_pkg::REG_BODY_LIMIT: cfg_q.body_limit <= cfg_data;
				hbd_pkg::REG_RAW_SLACK:  cfg_q.raw_slack <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// At most one result per transfer, so one free entry is enough to take it.
	assign s_axis_tready = room;
	assign take = s_axis_tvalid && room;

	hbd_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.kind           (s_axis_tuser),
		.body_mode      (s_axis_tdata[1:0]),
		.content_length (s_axis_tdata[18:2]),
		.rx_byte        (s_axis_tdata[26:19]),
		.cfg            (cfg_q),
		.res_vld        (res_vld),
		.res            (res)
	);

	hbd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_vld),
		.push_data (res),
		.has_room  (room),
		.out_vld   (m_axis_tvalid),
		.out_rdy   (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tdata = {5'd0, out_res.status, out_res.out_byte};
	assign m_axis_tuser = {out_res.done_res, out_res.out_valid};

endmodule
